### rtl/core/rrd_pkg.sv
`timescale 1ns / 1ps

package rrd_pkg;

  localparam int QUOTIENT_BITS_DEF = 8;
  localparam int BYTE_W = 8;
  localparam int REM_W = 14;
  localparam int K_W = 4;
  localparam int SKIP_W = 3;
  localparam int RES_W = 22;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [K_W-1:0] K_MAX = 4'd14;
  localparam logic [K_W-1:0] K_RESET = 4'd4;
  localparam logic [SKIP_W-1:0] SKIP_RESET = 3'd0;
  localparam logic [RES_W-1:0] RES_MAX = 22'h1F_FFFF;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_RICE_PARAM = 1'b0,
    REG_FIRST_SKIP = 1'b1
  } reg_idx_t;

endpackage

### rtl/core/rice_residual_decoder_core.sv
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// in        in_valid / in_stall   code_byte, last_byte
// out       out_valid / out_stall residual, quotient_overflow, last_of_byte
// cfg       APB write/read        rice_parameter @0x0, first_bit_skip @0x4
//
// A byte is decoded combinationally from the input register into an eight-slot
// result batch; results leave the batch one per cycle through the output
// register, except while out_stall holds a valid result there.
// A byte passes the input register, then the batch, then the output register.
// rst is synchronous; it restores reset register values and empties the pipe.
// in_stall rises while the input register holds a byte that the batch cannot
// take: more than one result pending, or the last one behind a stalled output.

module rice_residual_decoder_core
  import rrd_pkg::*;
#(
  parameter int QUOTIENT_BITS = QUOTIENT_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CFG_ADDR_W-1:0]   paddr,
  input  logic [CFG_DATA_W-1:0]   pwdata,
  output logic [CFG_DATA_W-1:0]   prdata,
  output logic                    pready,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [BYTE_W-1:0]       code_byte,
  input  logic                    last_byte,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [RES_W-1:0] residual,
  output logic                    quotient_overflow,
  output logic                    last_of_byte
);

  logic [K_W-1:0]           k_eff;
  logic [SKIP_W-1:0]        skip;
  logic                     batch_ready;
  logic                     batch_load;
  logic [BYTE_W-1:0]        emit_mask;
  logic [QUOTIENT_BITS-1:0] emit_q   [BYTE_W];
  logic [REM_W-1:0]         emit_rem [BYTE_W];

  rrd_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .k_eff   (k_eff),
    .skip    (skip)
  );

  rrd_bit_decoder #(
    .QUOTIENT_BITS (QUOTIENT_BITS)
  ) u_dec (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .code_byte   (code_byte),
    .last_byte   (last_byte),
    .k_eff       (k_eff),
    .skip        (skip),
    .batch_ready (batch_ready),
    .batch_load  (batch_load),
    .emit_mask   (emit_mask),
    .emit_q      (emit_q),
    .emit_rem    (emit_rem)
  );

  rrd_result_out #(
    .QUOTIENT_BITS (QUOTIENT_BITS)
  ) u_out (
    .clk               (clk),
    .rst               (rst),
    .k_eff             (k_eff),
    .batch_ready       (batch_ready),
    .batch_load        (batch_load),
    .emit_mask         (emit_mask),
    .emit_q            (emit_q),
    .emit_rem          (emit_rem),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .residual          (residual),
    .quotient_overflow (quotient_overflow),
    .last_of_byte      (last_of_byte)
  );

endmodule

### rtl/core/rrd_apb_regs.sv
`timescale 1ns / 1ps

module rrd_apb_regs
  import rrd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [K_W-1:0]        k_eff,
  output logic [SKIP_W-1:0]     skip
);

  logic [K_W-1:0]    rice_parameter;
  logic [SKIP_W-1:0] first_bit_skip;
  reg_idx_t          idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx = reg_idx_t'(paddr[2]);
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rice_parameter <= K_RESET;
      first_bit_skip <= SKIP_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_RICE_PARAM: rice_parameter <= pwdata[K_W-1:0];
        REG_FIRST_SKIP: first_bit_skip <= pwdata[SKIP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_RICE_PARAM: prdata = CFG_DATA_W'(rice_parameter);
      REG_FIRST_SKIP: prdata = CFG_DATA_W'(first_bit_skip);
      default:        prdata = '0;
    endcase
  end

  // k of 15 acts as 14
  assign k_eff = (rice_parameter > K_MAX) ? K_MAX : rice_parameter;
  assign skip = first_bit_skip;

endmodule

### rtl/core/rrd_bit_decoder.sv
`timescale 1ns / 1ps

module rrd_bit_decoder
  import rrd_pkg::*;
#(
  parameter int QUOTIENT_BITS = QUOTIENT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [BYTE_W-1:0]        code_byte,
  input  logic                     last_byte,
  input  logic [K_W-1:0]           k_eff,
  input  logic [SKIP_W-1:0]        skip,
  input  logic                     batch_ready,
  output logic                     batch_load,
  output logic [BYTE_W-1:0]        emit_mask,
  output logic [QUOTIENT_BITS-1:0] emit_q [BYTE_W],
  output logic [REM_W-1:0]         emit_rem [BYTE_W]
);

  localparam logic [QUOTIENT_BITS-1:0] QMax = {QUOTIENT_BITS{1'b1}};

  // input register
  logic              byte_valid;
  logic [BYTE_W-1:0] byte_r;
  logic              last_r;

  // code state carried across bytes
  logic                     in_remainder;
  logic [QUOTIENT_BITS-1:0] quotient_count;
  logic [REM_W-1:0]         remainder_bits;
  logic [K_W-1:0]           bits_left;
  logic                     at_run_start;

  // per-bit state chain
  logic                     st_in_rem [BYTE_W+1];
  logic [QUOTIENT_BITS-1:0] st_q      [BYTE_W+1];
  logic [REM_W-1:0]         st_rem    [BYTE_W+1];
  logic [K_W-1:0]           st_left   [BYTE_W+1];

  logic [SKIP_W-1:0] start;
  logic              in_accept;

  assign batch_load = byte_valid && batch_ready;
  assign in_stall = byte_valid && !batch_ready;
  assign in_accept = in_valid && !in_stall;
  assign start = at_run_start ? skip : '0;

  assign st_in_rem[0] = in_remainder;
  assign st_q[0]      = quotient_count;
  assign st_rem[0]    = remainder_bits;
  assign st_left[0]   = bits_left;

  for (genvar i = 0; i < BYTE_W; i++) begin : g_bit
    logic                     b;
    logic                     active;
    logic                     n_in_rem;
    logic [QUOTIENT_BITS-1:0] n_q;
    logic [REM_W-1:0]         n_rem;
    logic [K_W-1:0]           n_left;
    logic                     e;
    logic [QUOTIENT_BITS-1:0] e_q;
    logic [REM_W-1:0]         e_rem;
    logic [REM_W-1:0]         sh;
    logic [K_W-1:0]           dec;

    assign b = byte_r[BYTE_W-1-i];
    assign active = (SKIP_W'(i) >= start);

    always_comb begin
      n_in_rem = st_in_rem[i];
      n_q = st_q[i];
      n_rem = st_rem[i];
      n_left = st_left[i];
      e = 1'b0;
      e_q = st_q[i];
      e_rem = st_rem[i];
      sh = {st_rem[i][REM_W-2:0], b};
      dec = (st_left[i] != '0) ? st_left[i] - 1'b1 : '0;
      if (active) begin
        if (!st_in_rem[i]) begin
          if (!b) begin
            if (st_q[i] != QMax) n_q = st_q[i] + 1'b1;
          end else if (k_eff == '0) begin
            e = 1'b1;
            e_rem = '0;
            n_q = '0;
            n_rem = '0;
            n_left = '0;
          end else begin
            n_in_rem = 1'b1;
            n_left = k_eff;
            n_rem = '0;
          end
        end else if (dec == '0) begin
          e = 1'b1;
          e_rem = sh;
          n_in_rem = 1'b0;
          n_q = '0;
          n_rem = '0;
          n_left = '0;
        end else begin
          n_rem = sh;
          n_left = dec;
        end
      end
    end

    assign st_in_rem[i+1] = n_in_rem;
    assign st_q[i+1]      = n_q;
    assign st_rem[i+1]    = n_rem;
    assign st_left[i+1]   = n_left;
    assign emit_mask[i]   = e;
    assign emit_q[i]      = e_q;
    assign emit_rem[i]    = e_rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_accept) begin
      byte_valid <= 1'b1;
    end else if (batch_load) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      byte_r <= code_byte;
      last_r <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_remainder   <= 1'b0;
      quotient_count <= '0;
      remainder_bits <= '0;
      bits_left      <= '0;
      at_run_start   <= 1'b1;
    end else if (batch_load) begin
      if (last_r) begin
        // drop the partial code, skip pending again
        in_remainder   <= 1'b0;
        quotient_count <= '0;
        remainder_bits <= '0;
        bits_left      <= '0;
        at_run_start   <= 1'b1;
      end else begin
        in_remainder   <= st_in_rem[BYTE_W];
        quotient_count <= st_q[BYTE_W];
        remainder_bits <= st_rem[BYTE_W];
        bits_left      <= st_left[BYTE_W];
        at_run_start   <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/rrd_result_out.sv
`timescale 1ns / 1ps

module rrd_result_out
  import rrd_pkg::*;
#(
  parameter int QUOTIENT_BITS = QUOTIENT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [K_W-1:0]           k_eff,
  output logic                     batch_ready,
  input  logic                     batch_load,
  input  logic [BYTE_W-1:0]        emit_mask,
  input  logic [QUOTIENT_BITS-1:0] emit_q [BYTE_W],
  input  logic [REM_W-1:0]         emit_rem [BYTE_W],
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [RES_W-1:0]  residual,
  output logic                     quotient_overflow,
  output logic                     last_of_byte
);

  localparam int VW = QUOTIENT_BITS + REM_W;
  localparam int CW = (VW > RES_W) ? VW + 1 : RES_W + 1;
  localparam int IW = $clog2(BYTE_W);
  localparam logic [QUOTIENT_BITS-1:0] QMax = {QUOTIENT_BITS{1'b1}};

  logic [BYTE_W-1:0]        mask;
  logic [QUOTIENT_BITS-1:0] slot_q   [BYTE_W];
  logic [REM_W-1:0]         slot_rem [BYTE_W];

  logic [IW-1:0]            pick;
  logic [BYTE_W-1:0]        mask_left;
  logic                     drain;
  logic [QUOTIENT_BITS-1:0] sel_q;
  logic [REM_W-1:0]         sel_rem;
  logic [CW-1:0]            v;
  logic [CW-1:0]            mag;
  logic [CW-1:0]            mag_p1;
  logic [RES_W-1:0]         res_next;

  // lowest pending slot first
  always_comb begin
    pick = '0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (mask[i]) pick = IW'(i);
    end
  end

  assign mask_left = mask & ~(BYTE_W'(1) << pick);
  assign drain = (mask != '0) && (!out_valid || !out_stall);
  assign batch_ready = (mask == '0) || (drain && mask_left == '0);

  assign sel_q = slot_q[pick];
  assign sel_rem = slot_rem[pick];

  // zigzag fold with saturation to the residual range
  always_comb begin
    v = (CW'(sel_q) << k_eff) | CW'(sel_rem);
    mag = v >> 1;
    mag_p1 = mag + 1'b1;
    if (!v[0]) begin
      res_next = (mag > CW'(RES_MAX)) ? RES_MAX : mag[RES_W-1:0];
    end else if (mag_p1 > CW'(RES_MAX) + 1'b1) begin
      res_next = ~RES_MAX;
    end else begin
      res_next = ~mag_p1[RES_W-1:0] + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (batch_load) begin
      mask <= emit_mask;
    end else if (drain) begin
      mask <= mask_left;
    end
  end

  always_ff @(posedge clk) begin
    if (batch_load) begin
      slot_q <= emit_q;
      slot_rem <= emit_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (drain) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      residual <= res_next;
      quotient_overflow <= (sel_q == QMax);
      last_of_byte <= (mask_left == '0);
    end
  end

endmodule
